### hdl/tccs_pkg.sv
// Shared widths, character codes, command codes and control structs of the text console.
package tccs_pkg;

	// Beat field widths
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int LOC_W   = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;

	// Packed stream widths, padded to whole bytes
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_TEXT_ATTR  = 1'b0;
	localparam logic REG_BLANK_ATTR = 1'b1;
	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h07;
	localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h05;

	// Commands
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

	// Controller to datapath
	typedef struct packed {
		logic take;      // input beat accepted this cycle
		logic step;      // advance the clear / scroll sweep by one cell
		logic load_out;  // load the result register
		logic out_read;  // result carries the read cell
	} tccs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scroll_need;  // the offered put overflows the last row
		logic sweep_last;   // sweep pointer sits on the last cell
	} tccs_stat_t;

endpackage

### hdl/tccs_ctrl.sv
// Controller state machine: handshakes, sequencing of reads and clear/scroll sweeps.
module tccs_ctrl
	import tccs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [CMD_W-1:0] s_command,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  tccs_stat_t       stat,
	output tccs_cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign m_tvalid = m_valid_q;

	// Decode the next step and the datapath commands
	always_comb begin
		state_d      = state_q;
		cmd.take     = 1'b0;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		cmd.out_read = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = s_tvalid && s_tready;
				if (cmd.take) begin
					case (s_command)
						CMD_PUT: begin
							if (stat.scroll_need) begin
								state_d = ST_SWEEP;
							end else begin
								cmd.load_out = 1'b1;
							end
						end
						CMD_CLEAR: state_d = ST_SWEEP;
						CMD_READ:  state_d = ST_RD;
						default:   cmd.load_out = 1'b1;
					endcase
				end
			end
			ST_RD: begin
				cmd.load_out = 1'b1;
				cmd.out_read = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.load_out = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// A result is never loaded over one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result register overwritten");

	// The drain cycle follows only the last sweep step
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q == ST_SWEEP && stat.sweep_last))
		else $error("drain entered before sweep end");

	// A read presents its beat in the cycle after the read state
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> m_valid_q)
		else $error("read result not presented");

endmodule

### hdl/tccs_dp.sv
// Datapath: cursor registers, screen memory, sweep pointer and result register.
module tccs_dp
	import tccs_pkg::*;
#(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CMD_W-1:0]  s_command,
	input  logic [CHAR_W-1:0] s_char_code,
	input  logic [IDX_W-1:0]  s_cell_index,
	input  logic [ATTR_W-1:0] text_attribute,
	input  logic [ATTR_W-1:0] blank_attribute,
	input  tccs_cmd_t         cmd,
	output tccs_stat_t        stat,
	output logic [COL_W-1:0]  cursor_column,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [LOC_W-1:0]  cursor_location,
	output logic [CELL_W-1:0] cell_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int RAW   = $clog2(CELLS + COLUMNS);
	localparam int CLW   = $clog2(COLUMNS);
	localparam int RWW   = $clog2(ROWS);
	localparam int PW    = $clog2(TAB_WIDTH);
	localparam int NCW   = $clog2(COLUMNS + TAB_WIDTH);
	localparam int NRW   = $clog2(ROWS + 1);

	// Cursor and tab phase (column modulo tab width)
	logic [CLW-1:0] col_q;
	logic [RWW-1:0] row_q;
	logic [PW-1:0]  phase_q;
	logic [CLW-1:0] col_d;
	logic [RWW-1:0] row_d;
	logic [PW-1:0]  phase_d;

	// Put evaluation
	logic [NCW-1:0] ncol;
	logic [NRW-1:0] nrow;
	logic [PW-1:0]  nphase;
	logic           scroll_need;
	logic           printable;
	logic           put_wr;
	logic [AW-1:0]  cur_loc;

	// Sweep
	logic [AW-1:0]  ptr_q;
	logic           clear_mode_q;
	logic           wr_s1;
	logic           blank_s1;
	logic [AW-1:0]  waddr_s1;
	logic [RAW-1:0] ahead;

	// Memory ports
	logic [CELL_W-1:0] mem [CELLS];
	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata_q;
	logic              rd_ok_q;

	// Result register
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [LOC_W-1:0]  out_loc_q;
	logic [CELL_W-1:0] out_cell_q;

	assign printable = (s_char_code >= CH_SPACE) && (s_char_code <= CH_LAST);
	assign cur_loc   = AW'(32'(row_q) * COLUMNS + 32'(col_q));

	// Work out the cursor after a put
	always_comb begin
		ncol   = NCW'(col_q);
		nrow   = NRW'(row_q);
		nphase = phase_q;
		case (s_char_code)
			CH_BS: begin
				if (col_q != '0) begin
					ncol   = NCW'(col_q) - NCW'(1);
					nphase = (phase_q == '0) ? PW'(TAB_WIDTH - 1) : phase_q - PW'(1);
				end
			end
			CH_TAB: begin
				ncol   = NCW'(col_q) + NCW'(TAB_WIDTH) - NCW'(phase_q);
				nphase = '0;
			end
			CH_CR: begin
				ncol   = '0;
				nphase = '0;
			end
			CH_LF: begin
				ncol   = '0;
				nphase = '0;
				nrow   = nrow + NRW'(1);
			end
			default: begin
				if (printable) begin
					ncol   = NCW'(col_q) + NCW'(1);
					nphase = (phase_q == PW'(TAB_WIDTH - 1)) ? '0 : phase_q + PW'(1);
				end
			end
		endcase
		// Wrap past the right edge
		if (ncol >= NCW'(COLUMNS)) begin
			ncol   = '0;
			nphase = '0;
			nrow   = nrow + NRW'(1);
		end
		scroll_need = (nrow >= NRW'(ROWS));
		if (scroll_need) begin
			nrow = NRW'(ROWS - 1);
		end
	end

	assign put_wr = cmd.take && (s_command == CMD_PUT) && printable;

	// Select the cursor after this cycle
	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		phase_d = phase_q;
		if (cmd.take) begin
			case (s_command)
				CMD_PUT: begin
					col_d   = CLW'(ncol);
					row_d   = RWW'(nrow);
					phase_d = nphase;
				end
				CMD_CLEAR: begin
					col_d   = '0;
					row_d   = '0;
					phase_d = '0;
				end
				default: ;
			endcase
		end
	end

	assign stat  = '{scroll_need: scroll_need, sweep_last: (ptr_q == AW'(CELLS - 1))};
	assign ahead = RAW'(ptr_q) + RAW'(COLUMNS);

	// Memory port selection
	assign we    = wr_s1 || put_wr;
	assign waddr = wr_s1 ? waddr_s1 : cur_loc;
	assign wdata = wr_s1 ? (blank_s1 ? {blank_attribute, CH_SPACE} : rdata_q)
	                     : {text_attribute, s_char_code};
	assign raddr = cmd.step ? AW'(ahead) : AW'(s_cell_index);

	// Screen memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Cursor, sweep pointer and copy stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			phase_q      <= '0;
			ptr_q        <= '0;
			clear_mode_q <= 1'b0;
			wr_s1        <= 1'b0;
			rd_ok_q      <= 1'b0;
		end else begin
			col_q   <= col_d;
			row_q   <= row_d;
			phase_q <= phase_d;
			wr_s1   <= cmd.step;
			if (cmd.take) begin
				ptr_q        <= '0;
				clear_mode_q <= (s_command == CMD_CLEAR);
				rd_ok_q      <= (32'(s_cell_index) < CELLS);
			end else if (cmd.step) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// Write half of the copy stage
	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q;
		blank_s1 <= clear_mode_q || (32'(ptr_q) >= CELLS - COLUMNS);
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_col_q  <= COL_W'(col_d);
			out_row_q  <= ROW_W'(row_d);
			out_loc_q  <= LOC_W'(32'(row_d) * COLUMNS + 32'(col_d));
			out_cell_q <= (cmd.out_read && rd_ok_q) ? rdata_q : '0;
		end
	end

	assign cursor_column   = out_col_q;
	assign cursor_row      = out_row_q;
	assign cursor_location = out_loc_q;
	assign cell_data       = out_cell_q;

	// Cursor stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor off screen");

	// A put write never meets a sweep write
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s1 && put_wr))
		else $error("memory write port conflict");

	// Sweep writes land inside the screen
	a_sweep_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (32'(waddr_s1) < CELLS))
		else $error("sweep write out of range");

endmodule

### hdl/text_console_cursor_scroll_top.sv
// Top level of the text console: configuration registers, beat packing, controller and datapath.
//
// Text console holding a COLUMNS x ROWS screen of 16-bit cells and a cursor.
// Input beats (s_tvalid/s_tready/s_tdata) carry a command: put a character byte,
// clear the screen, or read one cell. Every accepted beat yields exactly one
// output beat (m_tvalid/m_tready/m_tdata) with the cursor after the command,
// its linear location and, for a read, the cell contents.
// When the result register is loaded:
//   put without scroll, unused command: loaded at the accept edge itself, so
//   such beats stream at one per cycle while the receiver keeps up;
//   read: loaded in the read state from the registered read port of the screen memory;
//   clear, or a put that scrolls: after a sweep that steps through every cell,
//   one per step through the single write port, and a drain state for the last write.
// A new beat is taken only while no command is in progress and the result
// register is empty or being emptied; a stalled receiver therefore holds the
// input side after one pending result.
// Reset homes the cursor and loads the attribute registers; screen contents
// are undefined until cleared or written. Attribute registers are written
// over the APB port and must only change while the block is idle.
module text_console_cursor_scroll_top
	import tccs_pkg::*;
#(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// command[1:0], char_code[9:2], cell_index[20:10], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cursor_column[6:0], cursor_row[11:7], cursor_location[22:12], cell_data[38:23], pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic [ATTR_W-1:0] text_attribute_q;
	logic [ATTR_W-1:0] blank_attribute_q;
	logic              cfg_wr;

	logic [CMD_W-1:0]  command;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic [LOC_W-1:0]  cursor_location;
	logic [CELL_W-1:0] cell_data;

	tccs_cmd_t  cmd;
	tccs_stat_t stat;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q  <= TEXT_ATTR_RST;
			blank_attribute_q <= BLANK_ATTR_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BLANK_ATTR) begin
				blank_attribute_q <= pwdata[ATTR_W-1:0];
			end else begin
				text_attribute_q <= pwdata[ATTR_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_BLANK_ATTR) ? APB_DW'(blank_attribute_q)
	                                             : APB_DW'(text_attribute_q);

	// Unpack the input beat
	assign command    = s_tdata[CMD_W-1:0];
	assign char_code  = s_tdata[CMD_W +: CHAR_W];
	assign cell_index = s_tdata[CMD_W+CHAR_W +: IDX_W];

	// Pack the output beat
	assign m_tdata = {{(M_TDATA_W-COL_W-ROW_W-LOC_W-CELL_W){1'b0}},
	                  cell_data, cursor_location, cursor_row, cursor_column};

	tccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_command (command),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tccs_dp #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_command       (command),
		.s_char_code     (char_code),
		.s_cell_index    (cell_index),
		.text_attribute  (text_attribute_q),
		.blank_attribute (blank_attribute_q),
		.cmd             (cmd),
		.stat            (stat),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.cell_data       (cell_data)
	);

endmodule

### tb/sv/tb_text_console_cursor_scroll_top.sv
// Self-checking testbench for the text console: stream stimulus, APB setup and a cursor/screen predictor.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_top;
	import tccs_pkg::*;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = COLUMNS * ROWS;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Result beat field offsets, lowest field first
	localparam int COL_LO  = 0;
	localparam int ROW_LO  = COL_LO + COL_W;
	localparam int LOC_LO  = ROW_LO + ROW_W;
	localparam int CELL_LO = LOC_LO + LOC_W;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PRINT_CAP      = 100;

	typedef struct {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [LOC_W-1:0]  loc;
		logic [CELL_W-1:0] cell_word;
	} cursor_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 s_tvalid;
	logic                 s_tready;
	// command[1:0], char_code[9:2], cell_index[20:10], zero pad
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// cursor_column[6:0], cursor_row[11:7], cursor_location[22:12], cell_data[38:23], pad
	logic [M_TDATA_W-1:0] m_tdata;

	// Shadow of the screen, cursor and attributes
	logic [CELL_W-1:0] shadow_cells [CELLS];
	bit                shadow_known [CELLS];
	int                cursor_col;
	int                cursor_row;
	logic [ATTR_W-1:0] text_attr;
	logic [ATTR_W-1:0] blank_attr;

	cursor_report_t pending_reports[$];
	int  mismatch_count;
	int  results_checked;
	int  idle_cycles;
	bit  tx_gaps;
	bit  rx_gaps;
	bit  hold_req;

	text_console_cursor_scroll_top #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_WIDTH(TAB_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the shadow console by one command and return the report it yields
	function automatic cursor_report_t console_step(input logic [CMD_W-1:0] cmd,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		cursor_report_t rep;
		int col;
		int row;
		int pos;
		col = cursor_col;
		row = cursor_row;
		rep.cell_word = '0;
		case (cmd)
		CMD_PUT: begin
			if (ch == CH_BS) begin
				if (col != 0)
					col--;
			end else if (ch == CH_TAB) begin
				col = col + TAB_WIDTH - (col % TAB_WIDTH);
			end else if (ch == CH_CR) begin
				col = 0;
			end else if (ch == CH_LF) begin
				col = 0;
				row++;
			end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
				pos = row * COLUMNS + col;
				shadow_cells[pos] = {text_attr, ch};
				shadow_known[pos] = 1'b1;
				col++;
			end
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			// scroll up one line and blank the bottom one
			if (row >= ROWS) begin
				for (pos = 0; pos < CELLS - COLUMNS; pos++) begin
					shadow_cells[pos] = shadow_cells[pos + COLUMNS];
					shadow_known[pos] = shadow_known[pos + COLUMNS];
				end
				for (pos = CELLS - COLUMNS; pos < CELLS; pos++) begin
					shadow_cells[pos] = {blank_attr, CH_SPACE};
					shadow_known[pos] = 1'b1;
				end
				row = ROWS - 1;
			end
		end
		CMD_CLEAR: begin
			for (pos = 0; pos < CELLS; pos++) begin
				shadow_cells[pos] = {blank_attr, CH_SPACE};
				shadow_known[pos] = 1'b1;
			end
			col = 0;
			row = 0;
		end
		CMD_READ: begin
			if (idx < CELLS)
				rep.cell_word = shadow_cells[idx];
		end
		default: begin
		end
		endcase
		cursor_col = col;
		cursor_row = row;
		rep.col = COL_W'(col);
		rep.row = ROW_W'(row);
		rep.loc = LOC_W'(row * COLUMNS + col);
		return rep;
	endfunction

	// Pick a read index: mostly a cell already written, else an index past the end of the screen
	function automatic logic [IDX_W-1:0] pick_read_index();
		int n;
		int tries;
		if ($urandom_range(0, 6) != 0) begin
			for (tries = 0; tries < 40; tries++) begin
				n = $urandom_range(0, CELLS - 1);
				if (shadow_known[n])
					return IDX_W'(n);
			end
		end
		return IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1));
	endfunction

	task automatic report_mismatch(input string what, input logic [M_TDATA_W-1:0] got,
			input logic [M_TDATA_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] MISMATCH %s at result %0d: got 0x%0h, want 0x%0h",
				$realtime, what, results_checked, got, want);
		mismatch_count++;
	endtask

	// Offer one command beat, hold it until taken, then log its expected report
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({idx, ch, cmd});
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(console_step(cmd, ch, idx));
	endtask

	task automatic send_random_beat();
		int pick;
		int kind;
		logic [CHAR_W-1:0] ch;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 99);
		if (kind < 68)      ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
		else if (kind < 74) ch = CH_BS;
		else if (kind < 80) ch = CH_TAB;
		else if (kind < 84) ch = CH_CR;
		else if (kind < 89) ch = CH_LF;
		else if (kind < 94) ch = CHAR_W'($urandom_range(8'h00, 8'h1F));
		else                ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
		if (pick < 56)
			send_beat(CMD_PUT, ch, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
		else if (pick < 88)
			send_beat(CMD_READ, CHAR_W'($urandom_range(0, 255)), pick_read_index());
		else if (pick < 91)
			send_beat(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)),
				IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
		else if (pick < 93)
			send_beat(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
				IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
		else
			send_beat(CMD_PUT, CHAR_W'($urandom_range(0, 255)),
				IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
	endtask

	// Drop valid and wait until every report is in and the block is quiet
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic sel, input logic [ATTR_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_TEXT_ATTR)
			text_attr = value;
		else
			blank_attr = value;
	endtask

	task automatic set_attributes(input logic [ATTR_W-1:0] txt, input logic [ATTR_W-1:0] blk);
		drain_results();
		write_register(REG_TEXT_ATTR, txt);
		write_register(REG_BLANK_ATTR, blk);
	endtask

	// Unused command, reads past the screen, printing before any clear, control codes
	task automatic test_after_reset();
		send_beat(CMD_UNUSED, 8'hFF, '1);
		send_beat(CMD_READ, 8'h00, '1);
		send_beat(CMD_READ, 8'h00, IDX_W'(CELLS));
		send_beat(CMD_PUT, CH_BS, '0);
		send_beat(CMD_PUT, CH_LAST, '0);
		send_beat(CMD_PUT, CH_SPACE, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(0));
		send_beat(CMD_READ, 8'h00, IDX_W'(1));
		send_beat(CMD_PUT, 8'h80, '0);
		send_beat(CMD_PUT, 8'hFF, '0);
		send_beat(CMD_PUT, 8'h00, '0);
		send_beat(CMD_PUT, 8'h1F, '0);
		send_beat(CMD_PUT, 8'h0B, '0);
		send_beat(CMD_PUT, CH_BS, '0);
		send_beat(CMD_PUT, CH_TAB, '0);
		send_beat(CMD_PUT, CH_TAB, '0);
		send_beat(CMD_PUT, CH_CR, '0);
		send_beat(CMD_PUT, CH_LF, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(1));
	endtask

	// Clear with reset attributes, read both screen corners, then put a character and read it back
	task automatic test_clear_blank();
		send_beat(CMD_CLEAR, 8'h00, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
		send_beat(CMD_READ, 8'h00, IDX_W'(0));
		send_beat(CMD_PUT, 8'h7E, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(0));
	endtask

	task automatic test_attribute_extremes();
		set_attributes(8'hFF, 8'h00);
		send_beat(CMD_CLEAR, 8'h00, '0);
		send_beat(CMD_PUT, 8'h41, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(0));
		send_beat(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
		set_attributes(8'h00, 8'hFF);
		send_beat(CMD_CLEAR, 8'h00, '0);
		send_beat(CMD_PUT, 8'h5A, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'(0));
		send_beat(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
	endtask

	// Walk to the bottom line, then scroll by wrapping, by tabs and by line feed
	task automatic test_wrap_and_scroll();
		int k;
		set_attributes(ATTR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)));
		send_beat(CMD_CLEAR, 8'h00, '0);
		for (k = 0; k < ROWS - 1; k++)
			send_beat(CMD_PUT, CH_LF, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
		for (k = 0; k < COLUMNS; k++)
			send_beat(CMD_PUT, CHAR_W'($urandom_range(CH_SPACE, CH_LAST)), '0);
		for (k = 0; k < 6; k++)
			send_beat(CMD_READ, 8'h00,
				IDX_W'((ROWS - 2) * COLUMNS + $urandom_range(0, COLUMNS - 1)));
		send_beat(CMD_READ, 8'h00, IDX_W'(CELLS - 1));
		for (k = 0; k < COLUMNS / TAB_WIDTH; k++)
			send_beat(CMD_PUT, CH_TAB, '0);
		send_beat(CMD_PUT, CH_LF, '0);
		send_beat(CMD_PUT, CH_BS, '0);
		send_beat(CMD_READ, 8'h00, IDX_W'((ROWS - 4) * COLUMNS + 5));
		for (k = 0; k < 30; k++)
			send_random_beat();
	endtask

	// Random traffic in several attribute settings, idling switched in stretches
	task automatic test_random_phases();
		logic [ATTR_W-1:0] txt_set [6];
		logic [ATTR_W-1:0] blk_set [6];
		int p;
		int k;
		txt_set = '{8'h07, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h00};
		blk_set = '{8'h05, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'h00};
		for (p = 0; p < 6; p++) begin
			if (p >= 4) begin
				txt_set[p] = ATTR_W'($urandom_range(0, 255));
				blk_set[p] = ATTR_W'($urandom_range(0, 255));
			end
			set_attributes(txt_set[p], blk_set[p]);
			for (k = 0; k < 260; k++) begin
				if (k % 50 == 0) begin
					tx_gaps = ($urandom_range(0, 9) < 7);
					rx_gaps = ($urandom_range(0, 9) < 7);
				end
				send_random_beat();
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Hold the receiver off while beats keep coming, so the input side stalls
	task automatic test_backpressure();
		int k;
		tx_gaps  = 1'b0;
		hold_req = 1'b1;
		for (k = 0; k < 30; k++)
			send_random_beat();
	endtask

	task automatic test_quiet_tail();
		int k;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		for (k = 0; k < 200; k++)
			send_random_beat();
	endtask

	// Receiver: random stalls, or one long hold-off on request
	initial begin : result_sink
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest expected report
	always @(posedge clk) begin
		cursor_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result with none expected", m_tdata, '0);
			end else begin
				want = pending_reports.pop_front();
				if (m_tdata[COL_LO +: COL_W] !== want.col)
					report_mismatch("cursor_column", M_TDATA_W'(m_tdata[COL_LO +: COL_W]),
						M_TDATA_W'(want.col));
				if (m_tdata[ROW_LO +: ROW_W] !== want.row)
					report_mismatch("cursor_row", M_TDATA_W'(m_tdata[ROW_LO +: ROW_W]),
						M_TDATA_W'(want.row));
				if (m_tdata[LOC_LO +: LOC_W] !== want.loc)
					report_mismatch("cursor_location", M_TDATA_W'(m_tdata[LOC_LO +: LOC_W]),
						M_TDATA_W'(want.loc));
				if (m_tdata[CELL_LO +: CELL_W] !== want.cell_word)
					report_mismatch("cell_data", M_TDATA_W'(m_tdata[CELL_LO +: CELL_W]),
						M_TDATA_W'(want.cell_word));
			end
			results_checked++;
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles", $realtime, idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		tx_gaps         = 1'b1;
		rx_gaps         = 1'b1;
		hold_req        = 1'b0;
		mismatch_count  = 0;
		results_checked = 0;
		idle_cycles     = 0;
		cursor_col      = 0;
		cursor_row      = 0;
		text_attr       = TEXT_ATTR_RST;
		blank_attr      = BLANK_ATTR_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_clear_blank();
		test_attribute_extremes();
		test_wrap_and_scroll();
		test_random_phases();
		test_backpressure();
		test_quiet_tail();

		// wait out the longest sweep so a stray result still shows up
		drain_results();
		repeat (CELLS + 16) @(posedge clk);
		if (pending_reports.size() != 0)
			report_mismatch("reports never delivered", M_TDATA_W'(pending_reports.size()), '0);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
